>>> hdl/ceu_pkg.sv
// Shared types and constants for the 8-bit execute unit.
// Request and result payload structs, operation codes, status bit positions.
// No dependencies.
package ceu_pkg;

  // Operation codes, alphabetical, illegal last
  typedef enum logic [5:0] {
    OP_ADC, OP_AND, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI, OP_BNE, OP_BPL,
    OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_CMP, OP_CPX,
    OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR, OP_INC, OP_INX, OP_INY, OP_JMP,
    OP_JSR, OP_LDA, OP_LDX, OP_LDY, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA,
    OP_PLP, OP_RTS, OP_SEC, OP_SED, OP_SEI, OP_STA, OP_STX, OP_STY, OP_TAX,
    OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA, OP_ILL
  } ceu_op_e;

  // Status bit positions (N V 1 B D I Z C)
  localparam int unsigned FlagN = 7;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagU = 5;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagD = 3;
  localparam int unsigned FlagI = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  // Reset values
  localparam logic [7:0] SpReset    = 8'hFD;
  localparam logic [7:0] FlagsReset = 8'h24;

  // Bits forced on in a pushed status byte
  localparam logic [7:0] PushMask = 8'h30;

  typedef struct packed {
    logic [5:0]  mode;
    logic [7:0]  operand;
    logic [15:0] target_address;
    logic [15:0] next_pc;
  } ceu_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  accumulator;
    logic [7:0]  index_x_out;
    logic [7:0]  index_y_out;
    logic [7:0]  stack_pointer_out;
    logic [7:0]  status_out;
    logic [15:0] pc_out;
    logic        halted;
    logic        last;
  } ceu_out_t;

endpackage

>>> hdl/cpu_8bit_execute_unit.sv
// Execute stage of an 8-bit processor: register file, page-one stack, result register.
// Depends on ceu_pkg for payload structs, operation codes and flag positions.
//
// Usage:
//   Request channel (in_valid_i / in_stall_o / in_data_i) carries one decoded
//   instruction; it is taken at an edge with in_valid_i high and in_stall_o low.
//   Result channel (out_valid_o / out_stall_i / out_data_o) carries one result
//   per instruction, two for INC and DEC (unchanged byte first, last=0, then the
//   modified byte, last=1).
//   A request lands in the input register, executes from there and its result is
//   held in the result register until taken.
//   Throughput: one instruction per cycle while out_stall_i is low; INC and DEC
//   hold their request for two results, both through the single result register.
//   The stack lives in two 128-byte banks (even and odd addresses) so that a
//   two-byte push or pull uses one port of each bank. Bank reads are addressed from
//   the next stack pointer and registered, with write-to-read forwarding.
//   Reset: A, X, Y clear, SP=0xFD, status=0x24, halt clear; stack contents are
//   undefined until pushed. While out_stall_i is high the result holds and the
//   input register backs up, raising in_stall_o once it is full.
//   After BRK or an illegal operation every request is answered with one result
//   marked halted and unchanged registers.
module cpu_8bit_execute_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ceu_pkg::ceu_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ceu_pkg::ceu_out_t out_data_o
);
  import ceu_pkg::*;

  // Input register
  logic    in_valid_q;
  ceu_in_t in_q;

  // Architectural state
  logic [7:0] acc_q, acc_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] sp_q, sp_d;
  logic [7:0] flags_q, flags_d;
  logic       stopped_q, stopped_d;
  logic       rmw_q, rmw_d;

  // Result register
  logic     out_valid_q;
  ceu_out_t out_q, res_d;

  // Stack banks and read data
  logic [7:0] mem_even_q [128];
  logic [7:0] mem_odd_q  [128];
  logic [7:0] rd_even_q, rd_odd_q;

  // Handshake control
  logic exec_fire, in_retire, is_rmw;

  // Execute datapath
  logic [8:0]  sum;
  logic [8:0]  diff;
  logic [7:0]  cmp_reg;
  logic [7:0]  rmw_val;
  logic [15:0] ret_addr;
  logic [7:0]  pull_lo, pull_hi;
  logic        push_one, push_two;
  logic [7:0]  push0_data, push1_data;
  logic        nz_en;
  logic [7:0]  nz_val;
  logic        take_branch;

  // Bank ports
  logic       we_even, we_odd;
  logic [6:0] wa_even, wa_odd, ra_even, ra_odd;
  logic [7:0] wd_even, wd_odd;
  logic [7:0] sp_m1, sp_next, ra_byte_even, ra_byte_odd;

  // Advance the request when the result slot is free or being taken
  assign is_rmw    = (in_q.mode == OP_INC || in_q.mode == OP_DEC) && !stopped_q;
  assign exec_fire = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_retire = exec_fire && !(is_rmw && !rmw_q);
  assign in_stall_o = in_valid_q && !in_retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (in_retire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Stack pulls: sp+1 is in the even bank when sp is odd
  assign pull_lo = sp_q[0] ? rd_even_q : rd_odd_q;
  assign pull_hi = sp_q[0] ? rd_odd_q  : rd_even_q;

  assign sum      = {1'b0, acc_q} + {1'b0, in_q.operand} + {8'd0, flags_q[FlagC]};
  assign diff     = {1'b0, cmp_reg} - {1'b0, in_q.operand};
  assign ret_addr = in_q.next_pc - 16'd1;
  assign rmw_val  = (in_q.mode == OP_INC) ? in_q.operand + 8'd1 : in_q.operand - 8'd1;

  always_comb begin
    unique case (in_q.mode)
      OP_CPX:  cmp_reg = x_q;
      OP_CPY:  cmp_reg = y_q;
      default: cmp_reg = acc_q;
    endcase
  end

  // Execute one instruction against the current state
  always_comb begin
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    sp_d        = sp_q;
    flags_d     = flags_q;
    stopped_d   = stopped_q;
    rmw_d       = rmw_q;
    push_one    = 1'b0;
    push_two    = 1'b0;
    push0_data  = acc_q;
    push1_data  = ret_addr[7:0];
    nz_en       = 1'b0;
    nz_val      = 8'd0;
    take_branch = 1'b0;

    res_d               = '0;
    res_d.pc_out        = in_q.next_pc;
    res_d.last          = 1'b1;

    if (!stopped_q && !rmw_q) begin
      unique case (in_q.mode)
        OP_ADC: begin
          acc_d          = sum[7:0];
          flags_d[FlagC] = sum[8];
          flags_d[FlagV] = ~(acc_q[7] ^ in_q.operand[7]) & (acc_q[7] ^ sum[7]);
          nz_en          = 1'b1;
          nz_val         = sum[7:0];
        end
        OP_AND: begin
          acc_d = acc_q & in_q.operand; nz_en = 1'b1; nz_val = acc_q & in_q.operand;
        end
        OP_ORA: begin
          acc_d = acc_q | in_q.operand; nz_en = 1'b1; nz_val = acc_q | in_q.operand;
        end
        OP_EOR: begin
          acc_d = acc_q ^ in_q.operand; nz_en = 1'b1; nz_val = acc_q ^ in_q.operand;
        end
        OP_BCC: take_branch = !flags_q[FlagC];
        OP_BCS: take_branch = flags_q[FlagC];
        OP_BEQ: take_branch = flags_q[FlagZ];
        OP_BNE: take_branch = !flags_q[FlagZ];
        OP_BMI: take_branch = flags_q[FlagN];
        OP_BPL: take_branch = !flags_q[FlagN];
        OP_BVS: take_branch = flags_q[FlagV];
        OP_BVC: take_branch = !flags_q[FlagV];
        OP_JMP: take_branch = 1'b1;
        OP_BIT: begin
          flags_d[FlagV] = in_q.operand[6];
          flags_d[FlagN] = in_q.operand[7];
          flags_d[FlagZ] = (acc_q & in_q.operand) == 8'd0;
        end
        OP_CLC: flags_d[FlagC] = 1'b0;
        OP_CLD: flags_d[FlagD] = 1'b0;
        OP_CLI: flags_d[FlagI] = 1'b0;
        OP_CLV: flags_d[FlagV] = 1'b0;
        OP_SEC: flags_d[FlagC] = 1'b1;
        OP_SED: flags_d[FlagD] = 1'b1;
        OP_SEI: flags_d[FlagI] = 1'b1;
        OP_CMP, OP_CPX, OP_CPY: begin
          flags_d[FlagC] = !diff[8];
          nz_en          = 1'b1;
          nz_val         = diff[7:0];
        end
        OP_INC, OP_DEC: begin
          nz_en               = 1'b1;
          nz_val              = rmw_val;
          rmw_d               = 1'b1;
          res_d.write_valid   = 1'b1;
          res_d.write_address = in_q.target_address;
          res_d.write_data    = in_q.operand;
          res_d.last          = 1'b0;
        end
        OP_INX: begin x_d = x_q + 8'd1; nz_en = 1'b1; nz_val = x_q + 8'd1; end
        OP_INY: begin y_d = y_q + 8'd1; nz_en = 1'b1; nz_val = y_q + 8'd1; end
        OP_DEX: begin x_d = x_q - 8'd1; nz_en = 1'b1; nz_val = x_q - 8'd1; end
        OP_DEY: begin y_d = y_q - 8'd1; nz_en = 1'b1; nz_val = y_q - 8'd1; end
        OP_JSR: begin
          push_two    = 1'b1;
          push0_data  = ret_addr[15:8];
          push1_data  = ret_addr[7:0];
          sp_d        = sp_q - 8'd2;
          take_branch = 1'b1;
        end
        OP_RTS: begin
          sp_d         = sp_q + 8'd2;
          res_d.pc_out = {pull_hi, pull_lo} + 16'd1;
        end
        OP_LDA: begin acc_d = in_q.operand; nz_en = 1'b1; nz_val = in_q.operand; end
        OP_LDX: begin x_d = in_q.operand; nz_en = 1'b1; nz_val = in_q.operand; end
        OP_LDY: begin y_d = in_q.operand; nz_en = 1'b1; nz_val = in_q.operand; end
        OP_NOP: ;
        OP_PHA: begin
          push_one   = 1'b1;
          push0_data = acc_q;
          sp_d       = sp_q - 8'd1;
        end
        OP_PHP: begin
          push_one       = 1'b1;
          push0_data     = flags_q | PushMask;
          sp_d           = sp_q - 8'd1;
          flags_d[FlagB] = 1'b1;
        end
        OP_PLA: begin
          sp_d   = sp_q + 8'd1;
          acc_d  = pull_lo;
          nz_en  = 1'b1;
          nz_val = pull_lo;
        end
        OP_PLP: begin
          sp_d    = sp_q + 8'd1;
          flags_d = pull_lo;
        end
        OP_STA: begin
          res_d.write_valid = 1'b1; res_d.write_address = in_q.target_address;
          res_d.write_data  = acc_q;
        end
        OP_STX: begin
          res_d.write_valid = 1'b1; res_d.write_address = in_q.target_address;
          res_d.write_data  = x_q;
        end
        OP_STY: begin
          res_d.write_valid = 1'b1; res_d.write_address = in_q.target_address;
          res_d.write_data  = y_q;
        end
        OP_TAX: begin x_d = acc_q; nz_en = 1'b1; nz_val = acc_q; end
        OP_TAY: begin y_d = acc_q; nz_en = 1'b1; nz_val = acc_q; end
        OP_TSX: begin x_d = sp_q; nz_en = 1'b1; nz_val = sp_q; end
        OP_TXA: begin acc_d = x_q; nz_en = 1'b1; nz_val = x_q; end
        OP_TXS: sp_d = x_q;
        OP_TYA: begin acc_d = y_q; nz_en = 1'b1; nz_val = y_q; end
        // BRK, illegal and unassigned codes stop the machine
        default: stopped_d = 1'b1;
      endcase

      if (nz_en) begin
        flags_d[FlagN] = nz_val[7];
        flags_d[FlagZ] = nz_val == 8'd0;
      end
      if (take_branch) begin
        res_d.pc_out = in_q.target_address;
      end
    end else if (!stopped_q) begin
      // Second half of a read-modify-write: state is already final
      rmw_d               = 1'b0;
      res_d.write_valid   = 1'b1;
      res_d.write_address = in_q.target_address;
      res_d.write_data    = rmw_val;
    end

    res_d.accumulator       = acc_d;
    res_d.index_x_out       = x_d;
    res_d.index_y_out       = y_d;
    res_d.stack_pointer_out = sp_d;
    res_d.status_out        = flags_d;
    res_d.halted            = stopped_d;
  end

  // Commit state when the instruction executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= 8'd0;
      x_q       <= 8'd0;
      y_q       <= 8'd0;
      sp_q      <= SpReset;
      flags_q   <= FlagsReset;
      stopped_q <= 1'b0;
      rmw_q     <= 1'b0;
    end else if (exec_fire) begin
      acc_q     <= acc_d;
      x_q       <= x_d;
      y_q       <= y_d;
      sp_q      <= sp_d;
      flags_q   <= flags_d;
      stopped_q <= stopped_d;
      rmw_q     <= rmw_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Route pushes at sp and sp-1 to the banks by address parity
  assign sp_m1   = sp_q - 8'd1;
  assign we_even = exec_fire && ((push_one || push_two) && !sp_q[0] || push_two && sp_q[0]);
  assign we_odd  = exec_fire && ((push_one || push_two) && sp_q[0] || push_two && !sp_q[0]);
  assign wa_even = sp_q[0] ? sp_m1[7:1] : sp_q[7:1];
  assign wa_odd  = sp_q[0] ? sp_q[7:1]  : sp_m1[7:1];
  assign wd_even = sp_q[0] ? push1_data : push0_data;
  assign wd_odd  = sp_q[0] ? push0_data : push1_data;

  // Read sp+1 and sp+2 of the stack pointer held after this edge, one from each bank
  assign sp_next      = exec_fire ? sp_d : sp_q;
  assign ra_byte_even = sp_next[0] ? sp_next + 8'd1 : sp_next + 8'd2;
  assign ra_byte_odd  = sp_next[0] ? sp_next + 8'd2 : sp_next + 8'd1;
  assign ra_even      = ra_byte_even[7:1];
  assign ra_odd       = ra_byte_odd[7:1];

  // Bank memories with write-to-read forwarding
  always_ff @(posedge clk_i) begin
    if (we_even) begin
      mem_even_q[wa_even] <= wd_even;
    end
    rd_even_q <= (we_even && wa_even == ra_even) ? wd_even : mem_even_q[ra_even];
  end

  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      mem_odd_q[wa_odd] <= wd_odd;
    end
    rd_odd_q <= (we_odd && wa_odd == ra_odd) ? wd_odd : mem_odd_q[ra_odd];
  end

`ifndef SYNTH
  // Second read-modify-write phase only with an instruction held
  assert property (@(posedge clk_i) disable iff (!rst_ni) rmw_q |-> in_valid_q)
    else $error("rmw phase without a held instruction");

  // A non-final result always carries the write-back byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> out_data_o.write_valid)
    else $error("non-final result without write");

  // The final write follows the first one directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last) |=>
    (out_valid_o && out_data_o.last && out_data_o.write_valid))
    else $error("second read-modify-write result missing");

  // Halt is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni) stopped_q |=> stopped_q)
    else $error("halt flag cleared");
`endif

endmodule

>>> bench/cpu_8bit_execute_unit_tb.sv
// Self-checking bench for cpu_8bit_execute_unit: directed and random instruction requests.
// A scoreboard class executes each request on its own register copy and checks results.
// Depends on ceu_pkg for payload structs, operation codes and flag positions.
module cpu_8bit_execute_unit_tb;
  import ceu_pkg::*;

  localparam int unsigned RandomItems = 1350;
  localparam int unsigned HaltedItems = 24;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 8;

  // Architectural copy of the execute unit plus the queue of results it owes
  class exec_scoreboard;
    logic [7:0] acc, xr, yr, sp, flags;
    bit         stopped;
    logic [7:0] stack_mem [256];
    bit         stack_set [256];
    ceu_out_t   owed_results [$];
    int unsigned errors;

    function new();
      acc = '0;
      xr = '0;
      yr = '0;
      sp = SpReset;
      flags = FlagsReset;
      stopped = 1'b0;
      errors = 0;
      foreach (stack_set[i]) begin
        stack_set[i] = 1'b0;
        stack_mem[i] = '0;
      end
    endfunction

    function void set_nz(logic [7:0] v);
      flags[FlagN] = v[7];
      flags[FlagZ] = (v == 8'h00);
    endfunction

    function void compare_reg(logic [7:0] r, logic [7:0] m);
      flags[FlagC] = (r >= m);
      set_nz(r - m);
    endfunction

    function void push(logic [7:0] v);
      stack_mem[sp] = v;
      stack_set[sp] = 1'b1;
      sp = sp - 8'd1;
    endfunction

    function logic [7:0] pull();
      sp = sp + 8'd1;
      return stack_mem[sp];
    endfunction

    // Queue one result built from the current register copy
    function void owe(bit wv, logic [15:0] wa, logic [7:0] wd, logic [15:0] pc, bit lst);
      ceu_out_t r;
      r.write_valid       = wv;
      r.write_address     = wv ? wa : 16'h0000;
      r.write_data        = wv ? wd : 8'h00;
      r.accumulator       = acc;
      r.index_x_out       = xr;
      r.index_y_out       = yr;
      r.stack_pointer_out = sp;
      r.status_out        = flags;
      r.pc_out            = pc;
      r.halted            = stopped;
      r.last              = lst;
      owed_results.push_back(r);
    endfunction

    // Execute one accepted request and queue what it must produce
    function void execute_request(ceu_in_t req);
      logic [7:0]  m, t, lo, hi;
      logic [8:0]  sum;
      logic [15:0] pc, tgt, ret;
      bit          wv;
      logic [7:0]  wd;
      m = req.operand;
      tgt = req.target_address;
      pc = req.next_pc;
      wv = 1'b0;
      wd = '0;
      if (stopped) begin
        owe(1'b0, '0, '0, req.next_pc, 1'b1);
        return;
      end
      case (req.mode)
        OP_ADC: begin
          sum = {1'b0, acc} + {1'b0, m} + {8'h00, flags[FlagC]};
          flags[FlagC] = sum[8];
          flags[FlagV] = ~(acc[7] ^ m[7]) & (acc[7] ^ sum[7]);
          acc = sum[7:0];
          set_nz(acc);
        end
        OP_AND: begin acc = acc & m; set_nz(acc); end
        OP_ORA: begin acc = acc | m; set_nz(acc); end
        OP_EOR: begin acc = acc ^ m; set_nz(acc); end
        OP_BCC: if (!flags[FlagC]) pc = tgt;
        OP_BCS: if (flags[FlagC]) pc = tgt;
        OP_BEQ: if (flags[FlagZ]) pc = tgt;
        OP_BNE: if (!flags[FlagZ]) pc = tgt;
        OP_BMI: if (flags[FlagN]) pc = tgt;
        OP_BPL: if (!flags[FlagN]) pc = tgt;
        OP_BVS: if (flags[FlagV]) pc = tgt;
        OP_BVC: if (!flags[FlagV]) pc = tgt;
        OP_BIT: begin
          flags[FlagV] = m[6];
          flags[FlagN] = m[7];
          flags[FlagZ] = ((acc & m) == 8'h00);
        end
        OP_CLC: flags[FlagC] = 1'b0;
        OP_CLD: flags[FlagD] = 1'b0;
        OP_CLI: flags[FlagI] = 1'b0;
        OP_CLV: flags[FlagV] = 1'b0;
        OP_SEC: flags[FlagC] = 1'b1;
        OP_SED: flags[FlagD] = 1'b1;
        OP_SEI: flags[FlagI] = 1'b1;
        OP_CMP: compare_reg(acc, m);
        OP_CPX: compare_reg(xr, m);
        OP_CPY: compare_reg(yr, m);
        OP_INC, OP_DEC: begin
          // read-modify-write: old byte goes back first, then the new one
          t = (req.mode == OP_INC) ? m + 8'd1 : m - 8'd1;
          set_nz(t);
          owe(1'b1, tgt, m, pc, 1'b0);
          owe(1'b1, tgt, t, pc, 1'b1);
          return;
        end
        OP_INX: begin xr = xr + 8'd1; set_nz(xr); end
        OP_INY: begin yr = yr + 8'd1; set_nz(yr); end
        OP_DEX: begin xr = xr - 8'd1; set_nz(xr); end
        OP_DEY: begin yr = yr - 8'd1; set_nz(yr); end
        OP_JMP: pc = tgt;
        OP_JSR: begin
          ret = req.next_pc - 16'd1;
          push(ret[15:8]);
          push(ret[7:0]);
          pc = tgt;
        end
        OP_RTS: begin
          lo = pull();
          hi = pull();
          pc = {hi, lo} + 16'd1;
        end
        OP_LDA: begin acc = m; set_nz(acc); end
        OP_LDX: begin xr = m; set_nz(xr); end
        OP_LDY: begin yr = m; set_nz(yr); end
        OP_NOP: ;
        OP_PHA: push(acc);
        OP_PHP: begin
          push(flags | PushMask);
          flags[FlagB] = 1'b1;
        end
        OP_PLA: begin acc = pull(); set_nz(acc); end
        OP_PLP: flags = pull();
        OP_STA: begin wv = 1'b1; wd = acc; end
        OP_STX: begin wv = 1'b1; wd = xr; end
        OP_STY: begin wv = 1'b1; wd = yr; end
        OP_TAX: begin xr = acc; set_nz(xr); end
        OP_TAY: begin yr = acc; set_nz(yr); end
        OP_TSX: begin xr = sp; set_nz(xr); end
        OP_TXA: begin acc = xr; set_nz(acc); end
        OP_TXS: sp = xr;
        OP_TYA: begin acc = yr; set_nz(acc); end
        // BRK, ILL and every undefined code stop the machine
        default: stopped = 1'b1;
      endcase
      owe(wv, tgt, wd, pc, 1'b1);
    endfunction

    function void check_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        $error("%s: expected %0h, got %0h", name, exp, act);
        errors++;
      end
    endfunction

    // Match one accepted result against the oldest owed one
    function void check_result(ceu_out_t got);
      ceu_out_t exp;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: %p", got);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      check_field("write_valid", exp.write_valid, got.write_valid);
      check_field("write_address", exp.write_address, got.write_address);
      check_field("write_data", exp.write_data, got.write_data);
      check_field("accumulator", exp.accumulator, got.accumulator);
      check_field("index_x_out", exp.index_x_out, got.index_x_out);
      check_field("index_y_out", exp.index_y_out, got.index_y_out);
      check_field("stack_pointer_out", exp.stack_pointer_out, got.stack_pointer_out);
      check_field("status_out", exp.status_out, got.status_out);
      check_field("pc_out", exp.pc_out, got.pc_out);
      check_field("halted", exp.halted, got.halted);
      check_field("last", exp.last, got.last);
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ceu_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ceu_out_t out_data_o;

  exec_scoreboard sb;
  int unsigned    cycles = 0;
  int unsigned    send_burst = 0;
  int unsigned    stall_left = 0;
  int unsigned    calm_left = 0;

  cpu_8bit_execute_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  // Gap lengths: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 96) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ceu_in_t make_req(logic [5:0] mode, logic [7:0] operand,
                                       logic [15:0] target, logic [15:0] npc);
    ceu_in_t req;
    req.mode = mode;
    req.operand = operand;
    req.target_address = target;
    req.next_pc = npc;
    return req;
  endfunction

  // Random live instruction; pulls only land on stack entries already pushed
  function automatic ceu_in_t random_request();
    ceu_op_e    op;
    logic [7:0] up1, up2;
    up1 = sb.sp + 8'd1;
    up2 = sb.sp + 8'd2;
    do op = ceu_op_e'($urandom_range(OP_TYA)); while (op == OP_BRK);
    if (op == OP_PLA && !sb.stack_set[up1]) op = OP_PHA;
    if (op == OP_PLP && !sb.stack_set[up1]) op = OP_PHP;
    if (op == OP_RTS && !(sb.stack_set[up1] && sb.stack_set[up2])) op = OP_JSR;
    return make_req(op, rand_byte(), rand_word(), rand_word());
  endfunction

  // Present one request after a random gap and hold it until taken
  task automatic send_request(input ceu_in_t req);
    int unsigned gap;
    if (send_burst != 0) begin
      send_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(99) < 4) send_burst = $urandom_range(200, 40);
      gap = ($urandom_range(99) < 55) ? 0 : pick_gap();
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stall the result side in random stretches, with calm periods between
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (calm_left != 0) calm_left <= calm_left - 1;
      else if ($urandom_range(99) < 25) stall_left <= pick_gap();
      else if ($urandom_range(99) < 3) calm_left <= $urandom_range(200, 40);
    end
  end

  // Note accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.execute_request(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // Drop the run if it hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("cpu_8bit_execute_unit_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [5:0] halt_mode;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Flag extremes, overflow and carry out of ADC
    send_request(make_req(OP_LDA, 8'h00, 16'h0000, 16'h0000));
    send_request(make_req(OP_LDA, 8'h80, 16'hFFFF, 16'hFFFF));
    send_request(make_req(OP_LDA, 8'h7F, 16'h1234, 16'h0002));
    send_request(make_req(OP_ADC, 8'h01, 16'h0000, 16'h0004));
    send_request(make_req(OP_ADC, 8'hFF, 16'h0000, 16'h0006));
    // BIT with A AND operand nonzero, then an untaken branch to the top address
    send_request(make_req(OP_BIT, 8'h40, 16'h0000, 16'h0008));
    send_request(make_req(OP_BEQ, 8'h00, 16'hFFFF, 16'h000A));
    send_request(make_req(OP_CMP, 8'h00, 16'h0000, 16'h000C));
    // Read-modify-write wrapping both ways
    send_request(make_req(OP_INC, 8'hFF, 16'hFFFF, 16'h000E));
    send_request(make_req(OP_DEC, 8'h00, 16'h0000, 16'h0010));
    send_request(make_req(OP_STA, 8'h55, 16'hFFFF, 16'h0012));
    // Status push and pull round trip
    send_request(make_req(OP_PHP, 8'h00, 16'h0000, 16'h0014));
    send_request(make_req(OP_PLP, 8'hFF, 16'h0000, 16'h0016));
    // Stack pointer at zero: JSR pushes wrap, return address wraps
    send_request(make_req(OP_LDX, 8'h00, 16'h0000, 16'h0018));
    send_request(make_req(OP_TXS, 8'h00, 16'h0000, 16'h001A));
    send_request(make_req(OP_JSR, 8'h00, 16'hABCD, 16'h0000));
    send_request(make_req(OP_RTS, 8'h00, 16'h0000, 16'hABCF));
    send_request(make_req(OP_PHA, 8'h00, 16'h0000, 16'h001C));
    send_request(make_req(OP_PLA, 8'h00, 16'h0000, 16'h001E));
    send_request(make_req(OP_LDX, 8'hFF, 16'h0000, 16'h0020));
    send_request(make_req(OP_INX, 8'h00, 16'h0000, 16'h0022));
    send_request(make_req(OP_DEY, 8'h00, 16'h0000, 16'h0024));
    send_request(make_req(OP_TSX, 8'h00, 16'h0000, 16'h0026));

    // Random live instructions
    repeat (RandomItems) send_request(random_request());

    // Stop the machine, then show every request is ignored
    case ($urandom_range(2))
      0: halt_mode = OP_BRK;
      1: halt_mode = OP_ILL;
      default: halt_mode = 6'($urandom_range(63, 51));
    endcase
    send_request(make_req(halt_mode, rand_byte(), rand_word(), rand_word()));
    send_request(make_req(OP_INC, rand_byte(), rand_word(), rand_word()));
    repeat (HaltedItems)
      send_request(make_req(6'($urandom_range(63)), rand_byte(), rand_word(), rand_word()));
    in_valid_i <= 1'b0;

    // Drain owed results, then allow for anything stray
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("cpu_8bit_execute_unit_tb: PASS");
    end else begin
      $display("cpu_8bit_execute_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ceu_pkg.sv
hdl/cpu_8bit_execute_unit.sv
bench/cpu_8bit_execute_unit_tb.sv
